### sv/tsva_pkg.sv
// Package for the temperature sample validate/average block.
// Holds the result beat type, register indexes and reset values.
// No dependencies.
`default_nettype none

package tsva_pkg;

    // Fixed field widths
    localparam int TIME_W = 32;
    localparam int TEMP_W = 12;
    localparam int WAIT_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONV_WAIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd2;

    // Register reset values
    localparam logic [WAIT_W-1:0]        CONV_WAIT_RST  = 10'd750;
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST  = -12'sd800;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 12'sd2000;

    // Saturation bounds of the average
    localparam int AVG_MAX = 2047;
    localparam int AVG_MIN = -2048;

    // One result beat
    typedef struct packed {
        logic                     start_conv;
        logic                     new_sample;
        logic                     fault;
        logic signed [TEMP_W-1:0] filtered;
    } result_t;

endpackage

`default_nettype wire

### sv/tsva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-during-write to the same address returns the old contents.
// No dependencies.
`default_nettype none

module tsva_ram #(
    parameter int WIDTH  = 12,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/temp_sample_validate_average.sv
// Temperature sample sequencer with range check and moving-average filter.
// Depends on tsva_pkg and tsva_ram.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat per millisecond tick,
//   carrying now_ms and reading. Output channel (out_valid / out_stall):
//   exactly one result beat per input beat, in order.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high;
//   index 0 conversion wait, 1 low limit, 2 high limit, others ignored.
//   Write configuration only while the block is idle.
// Timing:
//   An accepted beat's result is registered in the output register, or
//   in the skid register. Throughput is one beat per cycle while in_stall is
//   low: the ring entry to be replaced is read ahead of time from the sample
//   RAM, so the read-modify-write of the ring and running sum closes in the
//   accepting cycle. While the receiver stalls, one further beat is taken into
//   a skid register; in_stall rises when that register is occupied.
// Reset:
//   Idle phase, all state zero, registers at their reset values. The ring
//   is cleared by per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module temp_sample_validate_average #(
    parameter int FILTER_DEPTH = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tsva_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tsva_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [tsva_pkg::TIME_W-1:0]           now_ms,
    input  wire logic signed [tsva_pkg::TEMP_W-1:0]    reading,
    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       start_conv,
    output logic                                       new_sample,
    output logic                                       fault,
    output logic signed [tsva_pkg::TEMP_W-1:0]         filtered
);

    localparam int TEMP_W = tsva_pkg::TEMP_W;
    localparam int POS_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SUM_W  = TEMP_W + $clog2(FILTER_DEPTH);
    localparam int SHIFT  = $clog2(FILTER_DEPTH + 1) - 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FILTER_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(tsva_pkg::AVG_MAX);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(tsva_pkg::AVG_MIN);

    // Configuration registers
    logic [tsva_pkg::WAIT_W-1:0] wait_reg;
    logic signed [TEMP_W-1:0]    low_reg;
    logic signed [TEMP_W-1:0]    high_reg;

    // Sequencer and filter state
    logic                          converting_reg, converting_next;
    logic [tsva_pkg::TIME_W-1:0]   start_time_reg, start_time_next;
    logic [POS_W-1:0]              write_pos_reg, write_pos_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [TEMP_W-1:0]      average_reg, average_next;
    logic                          fault_reg, fault_next;
    logic [FILTER_DEPTH-1:0]       slot_valid_reg;

    // Read-ahead of the entry to be replaced
    logic                          rvalid_reg;
    logic                          fwd_hit_reg;
    logic signed [TEMP_W-1:0]      fwd_data_reg;
    logic [TEMP_W-1:0]             ram_rdata;

    // Output register and skid
    logic                          out_valid_reg, skid_valid_reg;
    tsva_pkg::result_t             out_data_reg, skid_data_reg;

    logic                          accept;
    logic                          read_tick;
    logic                          in_range;
    logic                          commit;
    logic signed [TEMP_W-1:0]      old_sample;
    logic signed [SUM_W-1:0]       shifted;
    logic [tsva_pkg::TIME_W-1:0]   elapsed;
    tsva_pkg::result_t             result;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= tsva_pkg::CONV_WAIT_RST;
            low_reg  <= tsva_pkg::LOW_LIMIT_RST;
            high_reg <= tsva_pkg::HIGH_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsva_pkg::REG_CONV_WAIT:  wait_reg <= cfg_data[tsva_pkg::WAIT_W-1:0];
                tsva_pkg::REG_LOW_LIMIT:  low_reg  <= signed'(cfg_data);
                tsva_pkg::REG_HIGH_LIMIT: high_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Old ring entry: forwarded write, stored value, or zero if never written
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            old_sample = fwd_data_reg;
        end
        else if (rvalid_reg)
        begin
            old_sample = signed'(ram_rdata);
        end
        else
        begin
            old_sample = '0;
        end
    end

    // Tick evaluation and state update
    always_comb
    begin
        elapsed   = now_ms - start_time_reg;
        read_tick = converting_reg && (elapsed >= tsva_pkg::TIME_W'(wait_reg));
        in_range  = !(reading < low_reg || reading > high_reg);
        commit    = accept && read_tick && in_range;

        converting_next = converting_reg;
        start_time_next = start_time_reg;
        write_pos_next  = write_pos_reg;
        sum_next        = sum_reg;
        average_next    = average_reg;
        fault_next      = fault_reg;

        shifted = (sum_reg - SUM_W'(old_sample) + SUM_W'(reading)) >>> SHIFT;

        if (accept)
        begin
            if (!converting_reg)
            begin
                start_time_next = now_ms;
                converting_next = 1'b1;
            end
            else if (read_tick)
            begin
                converting_next = 1'b0;
                if (!in_range)
                begin
                    fault_next   = 1'b1;
                    average_next = '0;
                end
                else
                begin
                    fault_next     = 1'b0;
                    sum_next       = sum_reg - SUM_W'(old_sample) + SUM_W'(reading);
                    write_pos_next = (write_pos_reg == LAST_POS) ? '0
                                                                 : write_pos_reg + 1'b1;
                    if (shifted > SAT_MAX)
                    begin
                        average_next = TEMP_W'(tsva_pkg::AVG_MAX);
                    end
                    else if (shifted < SAT_MIN)
                    begin
                        average_next = TEMP_W'(tsva_pkg::AVG_MIN);
                    end
                    else
                    begin
                        average_next = shifted[TEMP_W-1:0];
                    end
                end
            end
        end

        result.start_conv = !converting_reg;
        result.new_sample = commit;
        result.fault      = fault_next;
        result.filtered   = average_next;
    end

    // Sample ring storage
    tsva_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (FILTER_DEPTH),
        .ADDR_W(POS_W)
    ) u_ring (
        .clk  (clk),
        .we   (commit),
        .waddr(write_pos_reg),
        .wdata(reading),
        .raddr(write_pos_next),
        .rdata(ram_rdata)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            converting_reg <= 1'b0;
            start_time_reg <= '0;
            write_pos_reg  <= '0;
            sum_reg        <= '0;
            average_reg    <= '0;
            fault_reg      <= 1'b0;
            slot_valid_reg <= '0;
            rvalid_reg     <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            converting_reg <= converting_next;
            start_time_reg <= start_time_next;
            write_pos_reg  <= write_pos_next;
            sum_reg        <= sum_next;
            average_reg    <= average_next;
            fault_reg      <= fault_next;
            if (commit)
            begin
                slot_valid_reg[write_pos_reg] <= 1'b1;
            end
            rvalid_reg  <= slot_valid_reg[write_pos_next];
            fwd_hit_reg <= commit && (write_pos_reg == write_pos_next);
        end
    end

    // Forwarded write data, payload only
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= reading;
    end

    // Output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_conv = out_data_reg.start_conv;
    assign new_sample = out_data_reg.new_sample;
    assign fault      = out_data_reg.fault;
    assign filtered   = out_data_reg.filtered;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_start_not_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(start_conv && new_sample))
        else $error("a beat both starts a conversion and delivers a sample");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault) |-> (filtered == '0))
        else $error("filtered value non-zero on fault");

    a_commit_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> !converting_reg)
        else $error("sequencer still converting after a sample was taken");

endmodule

`default_nettype wire
